@@ hdl/spm_pkg.sv @@
// Shared types and field layout for the slotted page manager.
package spm_pkg;

  // Field widths of one request beat and one result beat.
  localparam int REQ_W     = 2;
  localparam int SLOT_W    = 10;
  localparam int LEN_W     = 12;
  localparam int IDX_W     = 12;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_RANGE   = 3'd2,
    ST_DELETED = 3'd3,
    ST_INDEX   = 3'd4
  } status_t;

  // One decoded request.
  typedef struct packed {
    req_t              req_type;
    logic [SLOT_W-1:0] slot_id;
    logic [LEN_W-1:0]  tuple_len;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] data_in;
  } req_item_t;

  // One result, apart from the page byte, which comes from the page memory.
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_out;
    logic [LEN_W-1:0]  record_len;
    logic              slot_valid;
    logic              data_sel;
  } result_t;

endpackage

@@ hdl/slotted_page_manager.sv @@
// Slotted page manager: one page of records with a separate slot directory.
//
//   Channel | Direction | Handshake              | Payload
//   s_*     | in        | s_tvalid / s_tready    | s_tuser: req_type; s_tdata: request fields
//   m_*     | out       | m_tvalid / m_tready    | m_tuser: status; m_tdata: result fields
//
// One request beat is taken per cycle while s_tready is high. A request
// passes through the request stage (directory read registered at accept)
// and then the output register, which holds its result. Reset clears the
// page bookkeeping; page and directory memories are not cleared. When
// m_tready is low while a result is held, the output register holds and
// the request stage holds behind it.
module slotted_page_manager #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 4,
  parameter int SLOT_BYTES   = 4,
  parameter int MAX_SLOTS    = 1023
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [9:0] slot_id, [21:10] tuple_len, [33:22] byte_index, [41:34] data_in, rest zero
  input  logic [spm_pkg::S_TDATA_W-1:0]  s_tdata,
  // [1:0] req_type
  input  logic [spm_pkg::REQ_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [9:0] slot_out, [17:10] data_out, [29:18] record_len, [30] slot_valid, [31] zero
  output logic [spm_pkg::M_TDATA_W-1:0]  m_tdata,
  // [2:0] status
  output logic [spm_pkg::STATUS_W-1:0]   m_tuser
);
  import spm_pkg::*;

  localparam int PAW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int PW  = $clog2(PAGE_BYTES + 1);
  localparam int DIW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SW  = $clog2(MAX_SLOTS + 1);
  localparam int XW  = (DIW > SLOT_W) ? DIW : SLOT_W;
  localparam int AW  = $clog2(HEADER_BYTES + MAX_SLOTS * SLOT_BYTES + PAGE_BYTES
                              + 2 * (1 << IDX_W) + SLOT_BYTES + 1) + 1;

  // Memories.
  logic [PW-1:0]     dir_off_mem  [MAX_SLOTS];
  logic [LEN_W-1:0]  dir_size_mem [MAX_SLOTS];
  logic [BYTE_W-1:0] page_mem     [PAGE_BYTES];

  // Unpacked request beat and pipeline registers.
  req_item_t         in_item;
  req_item_t         s1_item;
  logic              s1_valid;
  logic [PW-1:0]     dir_off_q;
  logic [LEN_W-1:0]  dir_size_q;
  result_t           out_res;
  logic              out_valid;
  logic [BYTE_W-1:0] page_q;

  // Page bookkeeping.
  logic [SW-1:0]     used_slots, used_slots_next;
  logic [PW-1:0]     free_top, free_top_next;
  logic [PW-1:0]     insert_base, insert_base_next;
  logic              insert_open, insert_open_next;
  logic [LEN_W-1:0]  last_size, last_size_next;

  // Last directory write, forwarded to a read issued at the same edge.
  logic              fwd_valid;
  logic [DIW-1:0]    fwd_slot;
  logic [PW-1:0]     fwd_off;
  logic [LEN_W-1:0]  fwd_size;

  // Request stage decisions.
  result_t           res;
  logic              dir_we;
  logic [DIW-1:0]    dir_waddr;
  logic [PW-1:0]     dir_woff;
  logic [LEN_W-1:0]  dir_wsize;
  logic              page_we;
  logic [PAW-1:0]    page_waddr;
  logic [PAW-1:0]    page_raddr;

  logic              out_ready;
  logic              in_acc;
  logic              s1_fire;
  logic [XW-1:0]     in_slot_x;
  logic [XW-1:0]     s1_slot_x;
  logic [DIW-1:0]    in_idx;
  logic [DIW-1:0]    s1_idx;

  logic [AW-1:0]     used_a, hdr_end, ft_a, room, len_a, slot_a;
  logic [AW-1:0]     ins_addr_a, rd_addr_a;
  logic [PW-1:0]     new_top;
  logic [PW-1:0]     cur_off;
  logic [LEN_W-1:0]  cur_size;
  logic              nospace;

  // Unpack the request beat.
  assign in_item.req_type   = req_t'(s_tuser);
  assign in_item.slot_id    = s_tdata[9:0];
  assign in_item.tuple_len  = s_tdata[21:10];
  assign in_item.byte_index = s_tdata[33:22];
  assign in_item.data_in    = s_tdata[41:34];

  // Handshake.
  assign out_ready = !out_valid || m_tready;
  assign s1_fire   = s1_valid && out_ready;
  assign s_tready  = !s1_valid || out_ready;
  assign in_acc    = s_tvalid && s_tready;

  assign in_slot_x = XW'(in_item.slot_id);
  assign s1_slot_x = XW'(s1_item.slot_id);
  assign in_idx    = in_slot_x[DIW-1:0];
  assign s1_idx    = s1_slot_x[DIW-1:0];

  // Request stage register and directory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (in_acc) begin
      s1_item    <= in_item;
      dir_off_q  <= dir_off_mem[in_idx];
      dir_size_q <= dir_size_mem[in_idx];
    end
  end

  // Directory write.
  always_ff @(posedge clk) begin
    if (s1_fire && dir_we) begin
      dir_off_mem[dir_waddr]  <= dir_woff;
      dir_size_mem[dir_waddr] <= dir_wsize;
    end
  end

  // Page memory: insert writes a byte, read fetches one into the result.
  always_ff @(posedge clk) begin
    if (s1_fire && page_we) begin
      page_mem[page_waddr] <= s1_item.data_in;
    end
    if (s1_fire) begin
      page_q <= page_mem[page_raddr];
    end
  end

  // Shared arithmetic for the request stage.
  always_comb begin
    used_a     = AW'(used_slots);
    hdr_end    = AW'(HEADER_BYTES) + used_a * AW'(SLOT_BYTES);
    ft_a       = AW'(free_top);
    room       = (ft_a > hdr_end) ? ft_a - hdr_end : '0;
    len_a      = AW'(s1_item.tuple_len);
    slot_a     = AW'(s1_item.slot_id);
    nospace    = (used_a >= AW'(MAX_SLOTS)) || (len_a + AW'(SLOT_BYTES) > room);
    new_top    = free_top - PW'(s1_item.tuple_len);
    ins_addr_a = AW'(insert_base) + AW'(s1_item.byte_index);
    // The entry read at accept may be stale by one write.
    if (fwd_valid && fwd_slot == s1_idx) begin
      cur_off  = fwd_off;
      cur_size = fwd_size;
    end else begin
      cur_off  = dir_off_q;
      cur_size = dir_size_q;
    end
    rd_addr_a  = AW'(cur_off) + AW'(s1_item.byte_index);
  end

  // Request decode and state update.
  always_comb begin
    res.status       = ST_OK;
    res.slot_out     = s1_item.slot_id;
    res.record_len   = '0;
    res.slot_valid   = 1'b0;
    res.data_sel     = 1'b0;
    used_slots_next  = used_slots;
    free_top_next    = free_top;
    insert_base_next = insert_base;
    insert_open_next = insert_open;
    last_size_next   = last_size;
    dir_we           = 1'b0;
    dir_waddr        = s1_idx;
    dir_woff         = '0;
    dir_wsize        = '0;
    page_we          = 1'b0;
    page_waddr       = ins_addr_a[PAW-1:0];
    page_raddr       = rd_addr_a[PAW-1:0];

    case (s1_item.req_type)
      REQ_INSERT: begin
        if (s1_item.byte_index == '0) begin
          // First byte: reserve room and a new slot.
          if (nospace) begin
            insert_open_next = 1'b0;
            res.status       = ST_NOSPACE;
            res.slot_out     = '0;
          end else begin
            free_top_next    = new_top;
            dir_we           = 1'b1;
            dir_waddr        = DIW'(used_slots);
            dir_woff         = new_top;
            dir_wsize        = s1_item.tuple_len;
            used_slots_next  = used_slots + SW'(1);
            insert_base_next = new_top;
            insert_open_next = 1'b1;
            last_size_next   = s1_item.tuple_len;
            page_we          = (s1_item.tuple_len != '0) &&
                               (AW'(new_top) < AW'(PAGE_BYTES));
            page_waddr       = new_top[PAW-1:0];
            res.slot_out     = SLOT_W'(used_slots);
            res.record_len   = s1_item.tuple_len;
            res.slot_valid   = (s1_item.tuple_len != '0);
          end
        end else if (!insert_open || used_slots == '0) begin
          res.status   = ST_INDEX;
          res.slot_out = '0;
        end else begin
          // Later byte of the open record.
          res.slot_out   = SLOT_W'(used_slots - SW'(1));
          res.record_len = last_size;
          res.slot_valid = (last_size != '0);
          if (s1_item.byte_index >= last_size || ins_addr_a >= AW'(PAGE_BYTES)) begin
            res.status = ST_INDEX;
          end else begin
            page_we = 1'b1;
          end
        end
      end
      REQ_QUERY: begin
        if (slot_a < used_a) begin
          res.record_len = cur_size;
          res.slot_valid = (cur_size != '0);
        end
      end
      default: begin
        // Delete and read.
        if (slot_a >= used_a) begin
          res.status = ST_RANGE;
        end else if (cur_off == '0 && cur_size == '0) begin
          res.status = ST_DELETED;
        end else if (s1_item.req_type == REQ_DELETE) begin
          dir_we = 1'b1;
          if (slot_a == used_a - AW'(1)) begin
            last_size_next = '0;
          end
        end else if (s1_item.byte_index >= cur_size || rd_addr_a >= AW'(PAGE_BYTES)) begin
          res.status     = ST_INDEX;
          res.record_len = cur_size;
          res.slot_valid = (cur_size != '0);
        end else begin
          res.record_len = cur_size;
          res.slot_valid = 1'b1;
          res.data_sel   = 1'b1;
        end
      end
    endcase
  end

  // Bookkeeping, forwarding and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_slots  <= '0;
      free_top    <= PW'(PAGE_BYTES);
      insert_base <= '0;
      insert_open <= 1'b0;
      last_size   <= '0;
      fwd_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (s1_fire) begin
        used_slots  <= used_slots_next;
        free_top    <= free_top_next;
        insert_base <= insert_base_next;
        insert_open <= insert_open_next;
        last_size   <= last_size_next;
        if (dir_we) begin
          fwd_valid <= 1'b1;
        end
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
    if (s1_fire) begin
      out_res <= res;
      if (dir_we) begin
        fwd_slot <= dir_waddr;
        fwd_off  <= dir_woff;
        fwd_size <= dir_wsize;
      end
    end
  end

  // Result beat.
  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {1'b0, out_res.slot_valid, out_res.record_len,
                     (out_res.data_sel ? page_q : BYTE_W'(0)), out_res.slot_out};

endmodule

@@ dv/tb_slotted_page_manager.sv @@
// Self-checking testbench for the slotted page manager: directed and random request streams.
module tb_slotted_page_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import spm_pkg::*;

  localparam int PAGE_SIZE    = 4096;
  localparam int HDR_BYTES    = 4;
  localparam int SLOT_COST    = 4;
  localparam int SLOT_LIMIT   = 1023;
  localparam int RANDOM_ITEMS = 950;
  localparam int STALL_LIMIT  = 2000;

  // One result beat split into its fields.
  typedef struct packed {
    status_t     status;
    logic [9:0]  slot;
    logic [7:0]  data;
    logic [11:0] len;
    logic        valid;
  } page_result_t;

  // Page model and the queue of results still owed by the block.
  class page_scoreboard;
    logic [7:0]  page_mem [PAGE_SIZE];
    bit          byte_written [PAGE_SIZE];
    int unsigned dir_off [SLOT_LIMIT];
    int unsigned dir_len [SLOT_LIMIT];
    int unsigned used_slots;
    int unsigned free_top;
    int unsigned insert_base;
    bit          insert_open;
    page_result_t expected_q [$];
    int          errors;

    function new();
      used_slots  = 0;
      free_top    = PAGE_SIZE;
      insert_base = 0;
      insert_open = 0;
      errors      = 0;
    endfunction

    function void store_byte(int unsigned addr, logic [7:0] value);
      page_mem[addr]     = value;
      byte_written[addr] = 1'b1;
    endfunction

    // True when a read of this slot and index would return a byte never stored.
    function bit reads_unwritten(int unsigned slot, int unsigned idx);
      if (slot >= used_slots) return 1'b0;
      if (dir_off[slot] == 0 && dir_len[slot] == 0) return 1'b0;
      if (idx >= dir_len[slot] || dir_off[slot] + idx >= PAGE_SIZE) return 1'b0;
      return !byte_written[dir_off[slot] + idx];
    endfunction

    // Apply one accepted request beat to the page and queue its result.
    function void note_request(req_item_t item);
      page_result_t e;
      int unsigned  slot, len, idx, hdr_end, room, off, sz, s;
      e    = '0;
      slot = 32'(item.slot_id);
      len  = 32'(item.tuple_len);
      idx  = 32'(item.byte_index);
      if (item.req_type == REQ_INSERT) begin
        if (idx == 0) begin
          // Start of a record: reserve room and the next directory entry.
          hdr_end = HDR_BYTES + used_slots * SLOT_COST;
          room = (free_top > hdr_end) ? free_top - hdr_end : 0;
          if (used_slots >= SLOT_LIMIT || len + SLOT_COST > room) begin
            insert_open = 1'b0;
            e.status = ST_NOSPACE;
          end else begin
            free_top -= len;
            s = used_slots;
            dir_off[s] = free_top;
            dir_len[s] = len;
            used_slots++;
            insert_base = free_top;
            insert_open = 1'b1;
            if (len > 0 && free_top < PAGE_SIZE) store_byte(free_top, item.data_in);
            e.status = ST_OK;
            e.slot = SLOT_W'(s);
            e.len = LEN_W'(len);
            e.valid = (len > 0);
          end
        end else if (!insert_open || used_slots == 0) begin
          e.status = ST_INDEX;
        end else begin
          // Later byte of the open record.
          s  = used_slots - 1;
          sz = dir_len[s];
          e.slot = SLOT_W'(s);
          e.len = LEN_W'(sz);
          if (idx >= sz || insert_base + idx >= PAGE_SIZE) begin
            e.status = ST_INDEX;
            e.valid = (sz > 0);
          end else begin
            store_byte(insert_base + idx, item.data_in);
            e.status = ST_OK;
            e.valid = 1'b1;
          end
        end
      end else if (slot >= used_slots) begin
        e.status = (item.req_type == REQ_QUERY) ? ST_OK : ST_RANGE;
        e.slot = SLOT_W'(slot);
      end else begin
        off = dir_off[slot];
        sz  = dir_len[slot];
        e.slot = SLOT_W'(slot);
        if (item.req_type == REQ_QUERY) begin
          e.status = ST_OK;
          e.len = LEN_W'(sz);
          e.valid = (sz > 0);
        end else if (off == 0 && sz == 0) begin
          e.status = ST_DELETED;
        end else if (item.req_type == REQ_DELETE) begin
          dir_off[slot] = 0;
          dir_len[slot] = 0;
          e.status = ST_OK;
        end else if (idx >= sz || off + idx >= PAGE_SIZE) begin
          e.status = ST_INDEX;
          e.len = LEN_W'(sz);
          e.valid = (sz > 0);
        end else begin
          e.status = ST_OK;
          e.data = page_mem[off + idx];
          e.len = LEN_W'(sz);
          e.valid = 1'b1;
        end
      end
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Match one result beat against the oldest outstanding expectation.
    function void check_result(page_result_t got);
      page_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result beat arrived with no request outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("status", 32'(exp_r.status), 32'(got.status));
      compare_field("slot_out", 32'(exp_r.slot), 32'(got.slot));
      compare_field("data_out", 32'(exp_r.data), 32'(got.data));
      compare_field("record_len", 32'(exp_r.len), 32'(got.len));
      compare_field("slot_valid", 32'(exp_r.valid), 32'(got.valid));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [REQ_W-1:0]      s_tuser = REQ_INSERT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  page_scoreboard sb = new();
  int tx_idle_pct = 12;
  int rx_idle_pct = 51;
  int items_sent = 0;
  int stall_cycles = 0;

  slotted_page_manager #(
    .PAGE_BYTES(PAGE_SIZE),
    .HEADER_BYTES(HDR_BYTES),
    .SLOT_BYTES(SLOT_COST),
    .MAX_SLOTS(SLOT_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random back-pressure, result checking and the stall counter.
  always @(posedge clk) begin : result_monitor
    page_result_t got;
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tuser);
      got.slot   = m_tdata[9:0];
      got.data   = m_tdata[17:10];
      got.len    = m_tdata[29:18];
      got.valid  = m_tdata[30];
      sb.check_result(got);
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // The run ends here if no beat moves for too long.
  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Drive one request beat, with random idle cycles ahead of it.
  task automatic send(req_t kind, int unsigned slot, int unsigned len, int unsigned idx,
                      int unsigned data);
    req_item_t item;
    item.req_type   = kind;
    item.slot_id    = slot[SLOT_W-1:0];
    item.tuple_len  = len[LEN_W-1:0];
    item.byte_index = idx[IDX_W-1:0];
    item.data_in    = data[BYTE_W-1:0];
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'd0, item.data_in, item.byte_index, item.tuple_len, item.slot_id};
    do @(posedge clk); while (!s_tready);
    sb.note_request(item);
    items_sent++;
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // Mostly a live slot, otherwise any slot below SLOT_LIMIT.
  function automatic int unsigned pick_slot(int live_pct);
    if (sb.used_slots != 0 && $urandom_range(99) < live_pct)
      return $urandom_range(0, sb.used_slots - 1);
    return $urandom_range(0, SLOT_LIMIT - 1);
  endfunction

  // A read that would land on a never-stored byte becomes a validity query.
  task automatic send_read(int unsigned slot, int unsigned idx);
    if (sb.reads_unwritten(slot, idx))
      send(REQ_QUERY, slot, $urandom_range(0, 4095), idx, $urandom_range(0, 255));
    else
      send(REQ_READ, slot, $urandom_range(0, 4095), idx, $urandom_range(0, 255));
  endtask

  // A whole record: the opening beat, its bytes in order, sometimes cut short or overrun.
  task automatic send_record();
    int unsigned len, last, r;
    r = $urandom_range(99);
    if (r < 3) len = $urandom_range(0, 4088);
    else if (r < 13) len = 0;
    else if (r < 85) len = $urandom_range(1, 12);
    else len = $urandom_range(13, 120);
    send(REQ_INSERT, $urandom_range(0, 1023), len, 0, $urandom_range(0, 255));
    if (!sb.insert_open) return;
    last = len;
    if (len > 120) last = $urandom_range(1, 16);
    else if ($urandom_range(9) == 0) last = $urandom_range(0, len);
    for (int i = 1; i < last; i++) begin
      if ($urandom_range(19) == 0)
        send(REQ_QUERY, pick_slot(80), $urandom_range(0, 4095), $urandom_range(0, 4095),
             $urandom_range(0, 255));
      send(REQ_INSERT, $urandom_range(0, 1023), $urandom_range(0, 4095), i,
           $urandom_range(0, 255));
    end
    if ($urandom_range(9) == 0) begin
      r = ((len == 0) ? 1 : len) + $urandom_range(0, 3);
      send(REQ_INSERT, $urandom_range(0, 1023), $urandom_range(0, 4095),
           (r > 4087) ? 4087 : r, $urandom_range(0, 255));
    end
  endtask

  // One random step of the workload.
  task automatic random_action();
    int unsigned pick, slot, sz, idx;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_record();
    end else if (pick < 65) begin
      slot = pick_slot(90);
      sz = (slot < sb.used_slots) ? sb.dir_len[slot] : 0;
      idx = (sz != 0 && $urandom_range(99) < 80) ? $urandom_range(0, sz - 1)
                                                 : $urandom_range(0, 4087);
      send_read(slot, idx);
    end else if (pick < 75) begin
      send(REQ_DELETE, pick_slot(80), $urandom_range(0, 4095), $urandom_range(0, 4095),
           $urandom_range(0, 255));
    end else if (pick < 85) begin
      send(REQ_QUERY, pick_slot(70), $urandom_range(0, 4095), $urandom_range(0, 4095),
           $urandom_range(0, 255));
    end else begin
      // Noise: stray insert bytes, reads and deletes anywhere.
      case ($urandom_range(2))
        0: send(REQ_INSERT, $urandom_range(0, 1023), $urandom_range(0, 4095),
                $urandom_range(1, 4087), $urandom_range(0, 255));
        1: send_read($urandom_range(0, SLOT_LIMIT - 1), $urandom_range(0, 4087));
        default: send(REQ_DELETE, $urandom_range(0, SLOT_LIMIT - 1), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 255));
      endcase
    end
  endtask

  initial begin : stimulus
    int goal;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty page, first record, edges of each request kind.
    send(REQ_QUERY, 0, 0, 0, 0);            // query on an empty directory
    send(REQ_READ, 1022, 0, 0, 0);          // highest slot, out of range
    send(REQ_DELETE, 5, 0, 0, 0);           // delete out of range
    send(REQ_INSERT, 0, 0, 3, 0);           // stray byte with no open record
    send(REQ_INSERT, 0, 3, 0, 'h00);        // slot 0, three bytes
    send(REQ_INSERT, 0, 0, 1, 'hFF);
    send(REQ_INSERT, 0, 0, 2, 'hA5);
    send(REQ_INSERT, 0, 0, 3, 'h11);        // one past the end of the record
    send(REQ_READ, 0, 0, 1, 0);
    send(REQ_READ, 0, 0, 4087, 0);          // index far beyond the record
    send(REQ_INSERT, 0, 0, 0, 'h33);        // zero-length record
    send(REQ_QUERY, 1, 0, 0, 0);
    send(REQ_READ, 1, 0, 0, 0);
    send(REQ_INSERT, 0, 4088, 0, 'h77);     // length 4088, no room left
    send(REQ_INSERT, 0, 0, 1, 'h77);        // the failed insert closed the record
    send(REQ_INSERT, 0, 2, 0, 'h5A);
    send(REQ_DELETE, 2, 0, 0, 0);           // delete the record still being written
    send(REQ_INSERT, 0, 0, 1, 'hC3);        // byte for the deleted open record
    send(REQ_DELETE, 2, 0, 0, 0);           // second delete of the same slot
    send(REQ_READ, 2, 0, 0, 0);
    send(REQ_QUERY, 2, 0, 0, 0);
    send(REQ_DELETE, 1, 0, 0, 0);           // delete of a zero-length record
    send(REQ_QUERY, 0, 0, 0, 0);
    wait_drained();

    // Random traffic in three idling phases, drained between phases.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 12; rx_idle_pct = 51; end
        1: begin tx_idle_pct = 51; rx_idle_pct = 12; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      goal = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < goal) random_action();
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
